FILE: sv/dcr_pkg.sv
// ---------------------------------------------------------------------------
// dcr_pkg: shared types and constants for the control ramp block
// Holds the configuration structures, register indexes, reset values and
// the reciprocal constants used by the scaling logic.
// ---------------------------------------------------------------------------
package dcr_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        CFG_STEER_STEP    = 3'd0,
        CFG_STEER_MIN     = 3'd1,
        CFG_STEER_MAX     = 3'd2,
        CFG_ACCEL_STEP    = 3'd3,
        CFG_BRAKE_STEP    = 3'd4,
        CFG_PEDAL_MIN     = 3'd5,
        CFG_PEDAL_MAX     = 3'd6,
        CFG_ALWAYS_UPDATE = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Payload widths.
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned STEER_W    = 8;
    localparam int unsigned PEDAL_W    = 11;
    localparam int unsigned SUM_W      = 10;

    // Fixed points of the transfer curves.
    localparam logic [7:0] STEER_CENTRE = 8'h80;
    localparam logic [7:0] PEDAL_ZERO   = 8'h30;
    localparam logic [7:0] LEVEL_FULL   = 8'hFF;
    localparam logic [6:0] STEER_LIMIT  = 7'h7F;
    localparam logic signed [SUM_W-1:0] DEAD_BAND = 10'sd2;

    // Steering scale is x*256/0x70 = x*16/7; floor(16*m/7) = (m*4682) >> 11.
    localparam logic [12:0] STEER_RECIP = 13'd4682;
    localparam int unsigned STEER_SHIFT = 11;
    // Pedal scale is x*256/0x61; floor(256*m/97) = (m*43241) >> 14.
    localparam logic [15:0] PEDAL_RECIP = 16'd43241;
    localparam int unsigned PEDAL_SHIFT = 14;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_STEER_STEP = 8'd4;
    localparam logic [7:0] RST_STEER_MIN  = 8'd32;
    localparam logic [7:0] RST_STEER_MAX  = 8'd224;
    localparam logic [7:0] RST_ACCEL_STEP = 8'd8;
    localparam logic [7:0] RST_BRAKE_STEP = 8'd8;
    localparam logic [7:0] RST_PEDAL_MIN  = 8'd48;
    localparam logic [7:0] RST_PEDAL_MAX  = 8'd144;
    localparam logic       RST_ALWAYS_UPD = 1'b1;

    typedef struct packed {
        logic [7:0] step;
        logic [7:0] min_pos;
        logic [7:0] max_pos;
        logic       always_update;
    } t_steer_cfg;

    typedef struct packed {
        logic [7:0] step;
        logic [7:0] min_lvl;
        logic [7:0] max_lvl;
    } t_pedal_cfg;

    typedef struct packed {
        logic left_held;
        logic right_held;
        logic crash_mode;
        logic crash_freeze;
    } t_steer_in;

endpackage

FILE: sv/dcr_steer.sv
// ---------------------------------------------------------------------------
// dcr_steer: steering ramp, dead band tracking and command scaling
// Holds the steering position, the dead band state and the held command.
// State advances on every enabled cycle; next values are presented combinationally.
// ---------------------------------------------------------------------------
module dcr_steer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  dcr_pkg::t_steer_in       i_btn,
    input  dcr_pkg::t_steer_cfg      i_cfg,
    output logic [7:0]               o_level,
    output logic signed [7:0]        o_cmd
);
    import dcr_pkg::*;

    logic [7:0]              r_pos;
    logic [7:0]              r_prev;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [7:0]       r_held;

    logic [7:0]              n_pos;
    logic [7:0]              n_prev;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [7:0]       n_held;

    logic signed [9:0] w_pos;
    logic signed [9:0] w_step;
    logic signed [9:0] w_min;
    logic signed [9:0] w_max;
    logic signed [9:0] w_ctr;
    logic signed [9:0] w_ramp;
    logic signed [9:0] w_clamp;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [8:0] w_off;
    logic [7:0]        w_mag;
    logic [20:0]       w_prod;
    logic [9:0]        w_quo;
    logic [6:0]        w_lim;
    logic signed [7:0] w_scaled;
    logic signed [7:0] w_new_cmd;
    logic              w_update;

    assign w_pos  = $signed({2'b00, r_pos});
    assign w_step = $signed({2'b00, i_cfg.step});
    assign w_min  = $signed({2'b00, i_cfg.min_pos});
    assign w_max  = $signed({2'b00, i_cfg.max_pos});
    assign w_ctr  = $signed({2'b00, STEER_CENTRE});

    // Ramp toward the pressed side, snapping to centre first; else return to centre.
    always_comb begin
        w_ramp = w_pos;
        if (i_btn.left_held) begin
            w_ramp = ((w_pos > w_ctr) ? w_ctr : w_pos) - w_step;
            if (w_ramp < w_min) w_ramp = w_min;
        end else if (i_btn.right_held) begin
            w_ramp = ((w_pos < w_ctr) ? w_ctr : w_pos) + w_step;
            if (w_ramp > w_max) w_ramp = w_max;
        end else if (w_pos < w_ctr) begin
            w_ramp = w_pos + w_step;
            if (w_ramp > w_ctr) w_ramp = w_ctr;
        end else if (w_pos > w_ctr) begin
            w_ramp = w_pos - w_step;
            if (w_ramp < w_ctr) w_ramp = w_ctr;
        end
    end

    // Final clamp; the minimum is tested first.
    always_comb begin
        if (w_ramp < w_min) w_clamp = w_min;
        else if (w_ramp > w_max) w_clamp = w_max;
        else w_clamp = w_ramp;
    end

    assign n_pos = w_clamp[7:0];

    // Scale (pos - centre) * 16 / 7, truncated toward zero and limited to +-127.
    assign w_off  = $signed({1'b0, n_pos}) - $signed({1'b0, STEER_CENTRE});
    assign w_mag  = w_off[8] ? 8'(-w_off) : w_off[7:0];
    assign w_prod = 21'(w_mag) * 21'(STEER_RECIP);
    assign w_quo  = w_prod[20:STEER_SHIFT];
    assign w_lim  = (w_quo > 10'(STEER_LIMIT)) ? STEER_LIMIT : w_quo[6:0];
    assign w_scaled = w_off[8] ? -$signed({1'b0, w_lim}) : $signed({1'b0, w_lim});
    assign w_new_cmd = i_btn.crash_freeze ? 8'sd0 : w_scaled;

    // Dead band tracking of the accumulated change.
    assign w_sum = r_sum + ($signed({2'b00, n_pos}) - $signed({2'b00, r_prev}));
    assign w_update = i_cfg.always_update || (w_sum > DEAD_BAND) || (w_sum < -DEAD_BAND);

    always_comb begin
        n_prev = r_prev;
        n_sum  = r_sum;
        n_held = r_held;
        if (i_btn.crash_mode) begin
            n_held = w_new_cmd;
        end else begin
            n_prev = n_pos;
            if (w_update) begin
                n_sum  = '0;
                n_held = w_new_cmd;
            end else begin
                n_sum = w_sum;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= STEER_CENTRE;
            r_prev <= STEER_CENTRE;
            r_sum  <= '0;
            r_held <= '0;
        end else if (i_en) begin
            r_pos  <= n_pos;
            r_prev <= n_prev;
            r_sum  <= n_sum;
            r_held <= n_held;
        end
    end

    assign o_level = n_pos;
    assign o_cmd   = n_held;

endmodule

FILE: sv/dcr_pedal.sv
// ---------------------------------------------------------------------------
// dcr_pedal: pedal level ramp and command scaling
// Ramps one pedal level up or down with saturation, clamps it and scales it
// as (p - 0x30) * 256 / 0x61 truncated toward zero.
// ---------------------------------------------------------------------------
module dcr_pedal (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_held,
    input  dcr_pkg::t_pedal_cfg      i_cfg,
    output logic signed [dcr_pkg::PEDAL_W-1:0] o_cmd
);
    import dcr_pkg::*;

    logic [7:0]  r_level;
    logic [7:0]  n_level;
    logic [8:0]  w_up;
    logic [7:0]  w_clamp;
    logic signed [8:0] w_off;
    logic [7:0]  w_mag;
    logic [23:0] w_prod;
    logic [9:0]  w_quo;

    // Saturating ramp within 0..255.
    assign w_up = {1'b0, r_level} + {1'b0, i_cfg.step};
    always_comb begin
        if (i_held) n_level = w_up[8] ? LEVEL_FULL : w_up[7:0];
        else        n_level = (r_level < i_cfg.step) ? 8'd0 : (r_level - i_cfg.step);
    end

    // Clamp; the minimum is tested first.
    always_comb begin
        if (n_level < i_cfg.min_lvl)      w_clamp = i_cfg.min_lvl;
        else if (n_level > i_cfg.max_lvl) w_clamp = i_cfg.max_lvl;
        else                              w_clamp = n_level;
    end

    // Scale by reciprocal multiply on the magnitude, then restore the sign.
    assign w_off  = $signed({1'b0, w_clamp}) - $signed({1'b0, PEDAL_ZERO});
    assign w_mag  = w_off[8] ? 8'(-w_off) : w_off[7:0];
    assign w_prod = 24'(w_mag) * 24'(PEDAL_RECIP);
    assign w_quo  = w_prod[23:PEDAL_SHIFT];
    assign o_cmd  = w_off[8] ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_en) begin
            r_level <= n_level;
        end
    end

endmodule

FILE: sv/digital_to_analog_control_ramp_core.sv
// ---------------------------------------------------------------------------
// digital_to_analog_control_ramp_core: button to analog control ramp
// Each accepted request is held in the input register, then one pass of ramp
// and scaling logic writes its result into the result register.
// Throughput: one request per cycle; the result register stalls only on
// downstream backpressure. Reset (synchronous, active low) centres steering,
// zeroes pedals and held command, and loads default configuration values.
// ---------------------------------------------------------------------------
module digital_to_analog_control_ramp_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [dcr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dcr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] left_held, [1] right_held, [2] accel_held, [3] brake_held,
    // [4] crash_mode, [5] crash_freeze, [7:6] zero
    input  logic [dcr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // Result stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] steer_cmd, [18:8] accel_cmd, [29:19] brake_cmd,
    // [37:30] steer_level, [39:38] zero
    output logic [dcr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import dcr_pkg::*;

    // Configuration registers.
    t_steer_cfg r_steer_cfg;
    t_pedal_cfg r_accel_cfg;
    t_pedal_cfg r_brake_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_cfg <= '{step: RST_STEER_STEP, min_pos: RST_STEER_MIN,
                             max_pos: RST_STEER_MAX, always_update: RST_ALWAYS_UPD};
            r_accel_cfg <= '{step: RST_ACCEL_STEP, min_lvl: RST_PEDAL_MIN,
                             max_lvl: RST_PEDAL_MAX};
            r_brake_cfg <= '{step: RST_BRAKE_STEP, min_lvl: RST_PEDAL_MIN,
                             max_lvl: RST_PEDAL_MAX};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEER_STEP:    r_steer_cfg.step <= i_cfg_data;
                CFG_STEER_MIN:     r_steer_cfg.min_pos <= i_cfg_data;
                CFG_STEER_MAX:     r_steer_cfg.max_pos <= i_cfg_data;
                CFG_ACCEL_STEP:    r_accel_cfg.step <= i_cfg_data;
                CFG_BRAKE_STEP:    r_brake_cfg.step <= i_cfg_data;
                CFG_PEDAL_MIN: begin
                    r_accel_cfg.min_lvl <= i_cfg_data;
                    r_brake_cfg.min_lvl <= i_cfg_data;
                end
                CFG_PEDAL_MAX: begin
                    r_accel_cfg.max_lvl <= i_cfg_data;
                    r_brake_cfg.max_lvl <= i_cfg_data;
                end
                CFG_ALWAYS_UPDATE: r_steer_cfg.always_update <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: the input stage moves on whenever the result
    // register is empty or being drained.
    logic       r_in_v;
    logic [5:0] r_in_d;
    logic       r_out_v;
    logic [OUT_DATA_W-1:0] r_out_d;
    logic       w_adv;
    logic       w_fire;

    assign w_adv  = !r_out_v || i_m_axis_tready;
    assign w_fire = r_in_v && w_adv;
    assign o_s_axis_tready = !r_in_v || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_in_v <= i_s_axis_tvalid;
            if (w_adv)           r_out_v <= r_in_v;
        end
    end

    // Input payload register.
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) r_in_d <= i_s_axis_tdata[5:0];
    end

    // Processing units.
    t_steer_in         w_btn;
    logic [7:0]        w_level;
    logic signed [7:0] w_steer_cmd;
    logic signed [PEDAL_W-1:0] w_accel_cmd;
    logic signed [PEDAL_W-1:0] w_brake_cmd;

    assign w_btn = '{left_held: r_in_d[0], right_held: r_in_d[1],
                     crash_mode: r_in_d[4], crash_freeze: r_in_d[5]};

    dcr_steer u_steer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_btn   (w_btn),
        .i_cfg   (r_steer_cfg),
        .o_level (w_level),
        .o_cmd   (w_steer_cmd)
    );

    dcr_pedal u_accel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_held  (r_in_d[2]),
        .i_cfg   (r_accel_cfg),
        .o_cmd   (w_accel_cmd)
    );

    dcr_pedal u_brake (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_held  (r_in_d[3]),
        .i_cfg   (r_brake_cfg),
        .o_cmd   (w_brake_cmd)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_d <= {2'b00, w_level, w_brake_cmd, w_accel_cmd, w_steer_cmd};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_d;

    // Checks on the pipeline control and the result ranges.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && !w_adv) |-> !o_s_axis_tready)
        else $error("input accepted while the input stage is stalled");

    a_fire_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_v)
        else $error("processed request did not reach the result register");

    a_steer_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_d[7:0] != 8'h80))
        else $error("steering command outside +-127");

    a_accel_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ($signed(r_out_d[18:8]) >= -11'sd127)
                    && ($signed(r_out_d[18:8]) <= 11'sd546))
        else $error("accelerator command out of range");

    a_idle_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_v && i_m_axis_tready) |=> !r_out_v)
        else $error("result appeared without a request in flight");

endmodule
